[rtl/core/segregated_fit_class_bitmap_defines.svh]
// assertion macros shared by the segregated-fit class manager
`ifndef SEGREGATED_FIT_CLASS_BITMAP_DEFINES_SVH
`define SEGREGATED_FIT_CLASS_BITMAP_DEFINES_SVH

// same-cycle implication
`define SFCB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfcb same-cycle check failed");

// next-cycle implication
`define SFCB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfcb next-cycle check failed");

`endif

[rtl/core/sfcb_pkg.sv]
`timescale 1ns / 1ps

package sfcb_pkg;

	// working width of a size after header add and rounding
	localparam int SW          = 34;
	localparam int MSB_W       = 6;
	localparam int SMALL_BITS  = 10;
	localparam int SMALL_LIMIT = 1024;
	localparam int LEVEL_BASE  = SMALL_BITS - 1;

	localparam int HDR_W        = 12;
	localparam int HEADER_RESET = 32;
	localparam int ADDR_W       = 3;
	localparam int DATA_W       = 32;

	localparam logic REG_HEADER = 1'b0;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_FIND   = 2'd2;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_NOFIT = 2'd1;
	localparam logic [1:0] STS_COUNT = 2'd2;

	localparam int OUT_FL_W = 5;
	localparam int OUT_SL_W = 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_CLASS,
		ST_LOOK,
		ST_SCAN,
		ST_RMW,
		ST_OUT
	} sfcb_state_t;

	// index of the leading one, zero for zero
	function automatic logic [MSB_W-1:0] msb_index(input logic [SW-1:0] v);
		logic [MSB_W-1:0] r;
		r = '0;
		for (int i = 0; i < SW; i++) begin
			if (v[i]) r = MSB_W'(i);
		end
		return r;
	endfunction

endpackage

[rtl/core/sfcb_ram.sv]
`timescale 1ns / 1ps

module sfcb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 368
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/segregated_fit_class_bitmap.sv]
`timescale 1ns / 1ps
// channel   dir  handshake              payload
// request   in   req_valid / req_stall  opcode, size
// result    out  res_valid / res_stall  status, first_level, second_level
// config    in   apb psel / penable     paddr, pwdata, prdata
// insert, remove: CLASS, LOOK, RMW states; find adds ROUND, and SCAN to move up a level
// out-of-range size or unused opcode ends in CLASS; find with no fit ends in LOOK
// the per-class counts live in one ram read in the cycle before the count update
// no clearing pass: a count whose second-level bit is clear reads as zero
// reset clears the bitmaps and the control state and loads the header register with 32
// a result held by res_stall sits in the output register, a further one waits in ST_OUT
`include "segregated_fit_class_bitmap_defines.svh"

module segregated_fit_class_bitmap #(
	parameter int FIRST_LEVELS = 23,
	parameter int SECOND_LOG2  = 4,
	parameter int COUNT_BITS   = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sfcb_pkg::ADDR_W-1:0]      paddr,
	input  logic [sfcb_pkg::DATA_W-1:0]      pwdata,
	output logic [sfcb_pkg::DATA_W-1:0]      prdata,
	output logic                             pready,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic [1:0]                       opcode,
	input  logic [31:0]                      size,
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic [1:0]                       status,
	output logic [sfcb_pkg::OUT_FL_W-1:0]    first_level,
	output logic [sfcb_pkg::OUT_SL_W-1:0]    second_level
);

	localparam int SEC         = 1 << SECOND_LOG2;
	localparam int FLW         = $clog2(FIRST_LEVELS);
	localparam int DEPTH       = FIRST_LEVELS << SECOND_LOG2;
	localparam int AW          = $clog2(DEPTH);
	localparam int SMALL_ROUND = (1 << (sfcb_pkg::SMALL_BITS - SECOND_LOG2)) - 1;

	sfcb_pkg::sfcb_state_t state_q, state_d;

	logic [1:0]                  op_q;
	logic [sfcb_pkg::SW-1:0]     s_q, s_d;
	logic [FLW-1:0]              fl_q, fl_d;
	logic [SECOND_LOG2-1:0]      sl_q, sl_d;
	logic [sfcb_pkg::HDR_W-1:0]  header_q;
	logic [FIRST_LEVELS-1:0]     top_q, top_d;
	logic [SEC-1:0]              rows_q [FIRST_LEVELS];

	logic [1:0]                  pend_status_q;
	logic [sfcb_pkg::OUT_FL_W-1:0] pend_fl_q;
	logic [sfcb_pkg::OUT_SL_W-1:0] pend_sl_q;
	logic                        res_valid_q;
	logic [1:0]                  res_status_q;
	logic [sfcb_pkg::OUT_FL_W-1:0] res_fl_q;
	logic [sfcb_pkg::OUT_SL_W-1:0] res_sl_q;

	logic                        req_accept;
	logic                        cfg_write;
	logic                        slot_free;
	logic [sfcb_pkg::MSB_W-1:0]  msb;
	logic                        below_limit;
	logic [sfcb_pkg::SW-1:0]     round_add;
	logic [sfcb_pkg::MSB_W-1:0]  fl_full;
	logic [SECOND_LOG2-1:0]      sl_calc;
	logic                        in_range;
	logic [SEC-1:0]              row;
	logic [SEC-1:0]              masked;
	logic [SEC-1:0]              ffs_sl_in;
	logic [SECOND_LOG2-1:0]      ffs_sl;
	logic [FIRST_LEVELS-1:0]     fmap;
	logic [FLW-1:0]              ffs_fl;
	logic [SEC-1:0]              sl_onehot;
	logic [COUNT_BITS-1:0]       cnt;
	logic [FIRST_LEVELS-1:0]     row_any;

	logic                        row_we;
	logic [SEC-1:0]              row_wdata;
	logic                        ram_re;
	logic                        ram_we;
	logic [COUNT_BITS-1:0]       ram_wdata;
	logic [COUNT_BITS-1:0]       ram_rdata;
	logic                        fin;
	logic [1:0]                  fin_status;
	logic [sfcb_pkg::OUT_FL_W-1:0] fin_fl;
	logic [sfcb_pkg::OUT_SL_W-1:0] fin_sl;
	logic                        res_load;
	logic                        pend_load;

	assign req_stall  = (state_q != sfcb_pkg::ST_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign slot_free  = !res_valid_q || !res_stall;

	// config port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_comb begin
		case (paddr[sfcb_pkg::ADDR_W-1])
			sfcb_pkg::REG_HEADER: prdata = {{(sfcb_pkg::DATA_W - sfcb_pkg::HDR_W){1'b0}}, header_q};
			default:              prdata = '0;
		endcase
	end

	// size classification, shared by rounding and class stages
	assign msb         = sfcb_pkg::msb_index(s_q);
	assign below_limit = s_q < sfcb_pkg::SW'(sfcb_pkg::SMALL_LIMIT);
	assign round_add   = below_limit ? sfcb_pkg::SW'(SMALL_ROUND)
	                           : (sfcb_pkg::SW'(1) << (msb - sfcb_pkg::MSB_W'(SECOND_LOG2)))
	                             - sfcb_pkg::SW'(1);
	assign fl_full     = below_limit ? '0 : msb - sfcb_pkg::MSB_W'(sfcb_pkg::LEVEL_BASE);
	assign sl_calc     = below_limit ? SECOND_LOG2'(s_q >> (sfcb_pkg::SMALL_BITS - SECOND_LOG2))
	                           : SECOND_LOG2'(s_q >> (msb - sfcb_pkg::MSB_W'(SECOND_LOG2)));
	assign in_range    = fl_full < sfcb_pkg::MSB_W'(FIRST_LEVELS);

	// bitmap row of the current first level
	assign row       = rows_q[fl_q];
	assign masked    = row & ({SEC{1'b1}} << sl_q);
	assign fmap      = top_q & (({FIRST_LEVELS{1'b1}} << fl_q) << 1);
	assign ffs_sl_in = (state_q == sfcb_pkg::ST_SCAN) ? row : masked;
	assign sl_onehot = SEC'(1) << sl_q;

	always_comb begin
		ffs_sl = '0;
		for (int i = SEC - 1; i >= 0; i--) begin
			if (ffs_sl_in[i]) ffs_sl = SECOND_LOG2'(i);
		end
	end

	always_comb begin
		ffs_fl = '0;
		for (int i = FIRST_LEVELS - 1; i >= 0; i--) begin
			if (fmap[i]) ffs_fl = FLW'(i);
		end
	end

	// count is zero whenever its bitmap bit is clear
	assign cnt = row[sl_q] ? ram_rdata : '0;

	always_comb begin
		for (int i = 0; i < FIRST_LEVELS; i++) begin
			row_any[i] = |rows_q[i];
		end
	end

	always_comb begin
		state_d    = state_q;
		s_d        = s_q;
		fl_d       = fl_q;
		sl_d       = sl_q;
		top_d      = top_q;
		row_we     = 1'b0;
		row_wdata  = row;
		ram_re     = 1'b0;
		ram_we     = 1'b0;
		ram_wdata  = '0;
		fin        = 1'b0;
		fin_status = sfcb_pkg::STS_NOFIT;
		fin_fl     = '0;
		fin_sl     = '0;
		res_load   = 1'b0;
		pend_load  = 1'b0;
		case (state_q)
			sfcb_pkg::ST_IDLE: begin
				if (req_accept) begin
					s_d = {2'b00, size}
					      + ((opcode == sfcb_pkg::OP_FIND) ? sfcb_pkg::SW'(header_q) : '0);
					state_d = (opcode == sfcb_pkg::OP_FIND) ? sfcb_pkg::ST_ROUND
					                                        : sfcb_pkg::ST_CLASS;
				end
			end
			sfcb_pkg::ST_ROUND: begin
				s_d     = s_q + round_add;
				state_d = sfcb_pkg::ST_CLASS;
			end
			sfcb_pkg::ST_CLASS: begin
				fl_d = FLW'(fl_full);
				sl_d = sl_calc;
				if (!in_range || (op_q != sfcb_pkg::OP_INSERT && op_q != sfcb_pkg::OP_REMOVE
				                  && op_q != sfcb_pkg::OP_FIND)) begin
					fin = 1'b1;
				end else begin
					state_d = sfcb_pkg::ST_LOOK;
				end
			end
			sfcb_pkg::ST_LOOK: begin
				if (op_q == sfcb_pkg::OP_FIND) begin
					if (|masked) begin
						sl_d    = ffs_sl;
						ram_re  = 1'b1;
						state_d = sfcb_pkg::ST_RMW;
					end else if (|fmap) begin
						fl_d    = ffs_fl;
						state_d = sfcb_pkg::ST_SCAN;
					end else begin
						fin = 1'b1;
					end
				end else begin
					ram_re  = 1'b1;
					state_d = sfcb_pkg::ST_RMW;
				end
			end
			sfcb_pkg::ST_SCAN: begin
				sl_d    = ffs_sl;
				ram_re  = 1'b1;
				state_d = sfcb_pkg::ST_RMW;
			end
			sfcb_pkg::ST_RMW: begin
				fin    = 1'b1;
				fin_fl = sfcb_pkg::OUT_FL_W'(fl_q);
				fin_sl = sfcb_pkg::OUT_SL_W'(sl_q);
				if (op_q == sfcb_pkg::OP_INSERT) begin
					if (&cnt) begin
						fin_status = sfcb_pkg::STS_COUNT;
					end else begin
						fin_status  = sfcb_pkg::STS_OK;
						ram_we      = 1'b1;
						ram_wdata   = cnt + COUNT_BITS'(1);
						row_we      = 1'b1;
						row_wdata   = row | sl_onehot;
						top_d[fl_q] = 1'b1;
					end
				end else if (cnt == '0) begin
					fin_status = sfcb_pkg::STS_COUNT;
				end else begin
					fin_status = sfcb_pkg::STS_OK;
					ram_we     = 1'b1;
					ram_wdata  = cnt - COUNT_BITS'(1);
					// last block of the class leaves
					if (cnt == COUNT_BITS'(1)) begin
						row_we    = 1'b1;
						row_wdata = row & ~sl_onehot;
						if (row_wdata == '0) top_d[fl_q] = 1'b0;
					end
				end
			end
			sfcb_pkg::ST_OUT: begin
				fin        = 1'b1;
				fin_status = pend_status_q;
				fin_fl     = pend_fl_q;
				fin_sl     = pend_sl_q;
			end
			default: begin
				state_d = sfcb_pkg::ST_IDLE;
			end
		endcase
		if (fin) begin
			if (slot_free) begin
				res_load = 1'b1;
				state_d  = sfcb_pkg::ST_IDLE;
			end else begin
				pend_load = 1'b1;
				state_d   = sfcb_pkg::ST_OUT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sfcb_pkg::ST_IDLE;
			header_q    <= sfcb_pkg::HDR_W'(sfcb_pkg::HEADER_RESET);
			top_q       <= '0;
			rows_q      <= '{default: '0};
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			top_q   <= top_d;
			if (row_we) rows_q[fl_q] <= row_wdata;
			if (cfg_write && paddr[sfcb_pkg::ADDR_W-1] == sfcb_pkg::REG_HEADER) begin
				header_q <= pwdata[sfcb_pkg::HDR_W-1:0];
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) op_q <= opcode;
		s_q  <= s_d;
		fl_q <= fl_d;
		sl_q <= sl_d;
		if (pend_load) begin
			pend_status_q <= fin_status;
			pend_fl_q     <= fin_fl;
			pend_sl_q     <= fin_sl;
		end
		if (res_load) begin
			res_status_q <= fin_status;
			res_fl_q     <= fin_fl;
			res_sl_q     <= fin_sl;
		end
	end

	sfcb_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(DEPTH)
	) u_counts (
		.clk  (clk),
		.we   (ram_we),
		.waddr({fl_q, sl_q}),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(AW'({fl_d, sl_d})),
		.rdata(ram_rdata)
	);

	assign res_valid    = res_valid_q;
	assign status       = res_status_q;
	assign first_level  = res_fl_q;
	assign second_level = res_sl_q;

	`SFCB_ASSERT_IMP(a_top_matches_rows, clk, arst_n, 1'b1, top_q == row_any)
	`SFCB_ASSERT_IMP(a_find_hits_nonempty, clk, arst_n,
		state_q == sfcb_pkg::ST_RMW && op_q == sfcb_pkg::OP_FIND, row[sl_q])
	`SFCB_ASSERT_IMP(a_write_in_range, clk, arst_n, ram_we,
		{1'b0, fl_q} < (FLW + 1)'(FIRST_LEVELS))
	`SFCB_ASSERT_NXT(a_accept_leaves_idle, clk, arst_n, req_accept,
		state_q != sfcb_pkg::ST_IDLE)

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	localparam int N_FL = 23;
	localparam int N_SL = 16;
	localparam int CNT_MAX = 65535;
	localparam int REG_SPARE = 1;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] sz;
	} alloc_req_t;

	typedef struct packed {
		logic [1:0] st;
		logic [4:0] fl;
		logic [3:0] sl;
	} alloc_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [sfcb_pkg::ADDR_W-1:0] paddr = '0;
	logic [sfcb_pkg::DATA_W-1:0] pwdata = '0;
	logic [sfcb_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [1:0] opcode = sfcb_pkg::OP_INSERT;
	logic [31:0] size = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [1:0] status;
	logic [sfcb_pkg::OUT_FL_W-1:0] first_level;
	logic [sfcb_pkg::OUT_SL_W-1:0] second_level;

	// mirror of the class bookkeeping
	logic [N_FL-1:0] top_map;
	logic [N_SL-1:0] row_map [N_FL];
	int unsigned blk_count [N_FL*N_SL];
	logic [11:0] hdr;

	alloc_req_t queued_reqs[$];
	alloc_res_t due_results[$];
	int unsigned live_sizes[$];
	alloc_req_t cur_req;
	alloc_res_t want;
	int reqs_queued = 0;
	int reqs_taken = 0;
	int hold_off = 0;
	int stall_left = 0;
	int nxt_stall;
	int fail_count = 0;
	int status_seen [4];
	int settings_done = 0;
	bit pace_on = 1'b1;

	segregated_fit_class_bitmap dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.opcode(opcode),
		.size(size),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status(status),
		.first_level(first_level),
		.second_level(second_level)
	);

	always #5 clk = ~clk;

	function automatic int lead_one(logic [33:0] v);
		for (int i = 33; i >= 0; i--) if (v[i]) return i;
		return 0;
	endfunction

	function automatic int low_set(logic [31:0] v);
		for (int i = 0; i < 32; i++) if (v[i]) return i;
		return 0;
	endfunction

	// returns 0 when the first level falls past the top class
	function automatic bit class_of(input logic [33:0] s, output int fl, output int sl);
		int m;
		if (s < 1024) begin
			fl = 0;
			sl = int'(s >> 6);
			return 1'b1;
		end
		m = lead_one(s);
		sl = int'((s >> (m - 4)) & 34'hF);
		fl = m - 9;
		return fl < N_FL;
	endfunction

	function automatic void drop_block(int fl, int sl);
		blk_count[fl*N_SL+sl]--;
		if (blk_count[fl*N_SL+sl] == 0) begin
			row_map[fl][sl] = 1'b0;
			if (row_map[fl] == '0) top_map[fl] = 1'b0;
		end
	endfunction

	function automatic alloc_res_t serve_request(logic [1:0] op, logic [31:0] sz);
		alloc_res_t r;
		int fl, sl, idx, rf, rs;
		logic [33:0] s;
		logic [N_SL-1:0] smap;
		logic [N_FL-1:0] fmap;
		bit hit;
		r.st = sfcb_pkg::STS_NOFIT;
		r.fl = '0;
		r.sl = '0;
		case (op)
			sfcb_pkg::OP_INSERT, sfcb_pkg::OP_REMOVE: begin
				if (class_of({2'b00, sz}, fl, sl)) begin
					idx = fl*N_SL + sl;
					r.fl = 5'(fl);
					r.sl = 4'(sl);
					if (op == sfcb_pkg::OP_INSERT) begin
						if (blk_count[idx] >= CNT_MAX) begin
							r.st = sfcb_pkg::STS_COUNT;
						end else begin
							blk_count[idx]++;
							row_map[fl][sl] = 1'b1;
							top_map[fl] = 1'b1;
							r.st = sfcb_pkg::STS_OK;
						end
					end else if (blk_count[idx] == 0) begin
						r.st = sfcb_pkg::STS_COUNT;
					end else begin
						drop_block(fl, sl);
						r.st = sfcb_pkg::STS_OK;
					end
				end
			end
			sfcb_pkg::OP_FIND: begin
				s = sz + hdr;
				// round up so any block of the target class fits
				if (s >= 1024) s += (34'd1 << (lead_one(s) - 4)) - 34'd1;
				else s += 34'd63;
				if (class_of(s, rf, rs)) begin
					smap = row_map[rf] & (16'hFFFF << rs);
					hit = 1'b1;
					if (smap == '0) begin
						fmap = top_map & ~((23'd1 << (rf + 1)) - 23'd1);
						if (fmap == '0) begin
							hit = 1'b0;
						end else begin
							rf = low_set(32'(fmap));
							smap = row_map[rf];
						end
					end
					if (hit && smap != '0) begin
						rs = low_set(32'(smap));
						if (blk_count[rf*N_SL+rs] != 0) begin
							drop_block(rf, rs);
							r.st = sfcb_pkg::STS_OK;
							r.fl = 5'(rf);
							r.sl = 4'(rs);
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			opcode <= sfcb_pkg::OP_INSERT;
			size <= '0;
			hold_off <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				due_results.push_back(serve_request(opcode, size));
				reqs_taken++;
			end
			if (!req_valid || !req_stall) begin
				if (hold_off == 0 && queued_reqs.size() != 0) begin
					cur_req = queued_reqs.pop_front();
					opcode <= cur_req.op;
					size <= cur_req.sz;
					req_valid <= 1'b1;
					hold_off <= pace_on ? $urandom_range(0, 8) : 0;
				end else begin
					req_valid <= 1'b0;
					if (hold_off != 0) hold_off <= hold_off - 1;
				end
			end
		end
	end

	task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (got_v !== exp_v) begin
			fail_count++;
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
		end
	endtask

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (due_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result: expected none, got status %0d class %0d/%0d",
						$time, status, first_level, second_level);
				end else begin
					want = due_results.pop_front();
					status_seen[want.st]++;
					compare_field("status", 32'(want.st), 32'(status));
					compare_field("first_level", 32'(want.fl), 32'(first_level));
					compare_field("second_level", 32'(want.sl), 32'(second_level));
				end
				nxt_stall = pace_on ? $urandom_range(0, 8) : 0;
			end else begin
				nxt_stall = (stall_left != 0) ? stall_left - 1 : 0;
			end
			stall_left <= nxt_stall;
			res_stall <= (nxt_stall != 0);
		end
	end

	task automatic write_reg(int index, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= sfcb_pkg::ADDR_W'(4 * index);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (index == int'(sfcb_pkg::REG_HEADER)) hdr = value[11:0];
		settings_done++;
	endtask

	// upper data bits are junk on purpose, the register keeps twelve
	task automatic set_header(logic [11:0] h);
		write_reg(int'(sfcb_pkg::REG_HEADER), ($urandom() & 32'hFFFF_F000) | 32'(h));
	endtask

	task automatic push_req(logic [1:0] op, logic [31:0] sz);
		alloc_req_t q;
		q.op = op;
		q.sz = sz;
		queued_reqs.push_back(q);
		reqs_queued++;
	endtask

	// roughly log-uniform so every class gets traffic
	function automatic logic [31:0] pick_size();
		int k;
		k = $urandom_range(0, 35);
		if (k <= 31) return ($urandom() >> (31 - k)) | (32'd1 << k);
		if (k == 32) return $urandom_range(0, 1023);
		if (k == 33) return 32'd0;
		if (k == 34) return 32'hFFFF_FFFF;
		return $urandom();
	endfunction

	task automatic add_random(int n);
		int pick, slot;
		logic [31:0] sz;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				sz = pick_size();
				live_sizes.push_back(sz);
				push_req(sfcb_pkg::OP_INSERT, sz);
			end else if (pick < 60) begin
				// mostly remove a block that was put in, sometimes a stray one
				if (live_sizes.size() != 0 && pick < 56) begin
					slot = $urandom_range(0, live_sizes.size() - 1);
					sz = live_sizes[slot];
					live_sizes.delete(slot);
				end else begin
					sz = pick_size();
				end
				push_req(sfcb_pkg::OP_REMOVE, sz);
			end else if (pick < 96) begin
				push_req(sfcb_pkg::OP_FIND, pick_size());
			end else begin
				push_req(OP_UNUSED, $urandom());
			end
		end
	endtask

	task automatic drain();
		while (reqs_taken != reqs_queued || due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int need;
		top_map = '0;
		foreach (row_map[i]) row_map[i] = '0;
		foreach (blk_count[i]) blk_count[i] = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		hdr = 12'(sfcb_pkg::HEADER_RESET);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed requests with the reset header
		push_req(sfcb_pkg::OP_FIND, 32'd0);
		push_req(sfcb_pkg::OP_REMOVE, 32'd0);
		push_req(sfcb_pkg::OP_INSERT, 32'd0);
		push_req(sfcb_pkg::OP_INSERT, 32'd1023);
		push_req(sfcb_pkg::OP_INSERT, 32'd1024);
		push_req(sfcb_pkg::OP_INSERT, 32'hFFFF_FFFF);
		push_req(sfcb_pkg::OP_INSERT, 32'h8000_0000);
		push_req(OP_UNUSED, 32'd1024);
		push_req(sfcb_pkg::OP_FIND, 32'd0);
		push_req(sfcb_pkg::OP_FIND, 32'd0);
		push_req(sfcb_pkg::OP_FIND, 32'd2000);
		push_req(sfcb_pkg::OP_FIND, 32'hFFFF_FFFF);
		push_req(sfcb_pkg::OP_FIND, 32'h77FF_FFE0);
		push_req(sfcb_pkg::OP_REMOVE, 32'd0);
		push_req(sfcb_pkg::OP_REMOVE, 32'd0);
		push_req(sfcb_pkg::OP_INSERT, 32'd1024);
		push_req(sfcb_pkg::OP_INSERT, 32'd1024);
		push_req(sfcb_pkg::OP_REMOVE, 32'd1024);
		push_req(sfcb_pkg::OP_FIND, 32'd1000);
		push_req(sfcb_pkg::OP_FIND, 32'd900);
		push_req(sfcb_pkg::OP_INSERT, 32'd512);
		push_req(sfcb_pkg::OP_REMOVE, 32'd512);
		push_req(sfcb_pkg::OP_INSERT, 32'd1);
		push_req(sfcb_pkg::OP_FIND, 32'd0);
		push_req(sfcb_pkg::OP_REMOVE, 32'hFFFF_FFFF);
		drain();

		set_header(12'd0);
		write_reg(REG_SPARE, $urandom());
		add_random(300);
		drain();

		set_header(12'hFFF);
		pace_on = 1'b0;
		add_random(250);
		drain();

		set_header(12'($urandom_range(1, 4094)));
		pace_on = 1'b1;
		add_random(300);
		drain();

		// pile blocks into one class, then remove one more than it holds
		set_header(12'd32);
		pace_on = 1'b0;
		repeat (20) push_req(sfcb_pkg::OP_INSERT, 32'h4000_0000);
		need = int'(blk_count[21*N_SL]) + 20;
		repeat (need + 1) push_req(sfcb_pkg::OP_REMOVE, 32'h4000_0000);
		push_req(sfcb_pkg::OP_INSERT, 32'h4000_0000);
		drain();

		set_header(12'($urandom_range(0, 4095)));
		pace_on = 1'b1;
		add_random(350);
		drain();

		$display("checked %0d results over %0d register writes", reqs_taken, settings_done);
		$display("status mix: %0d ok, %0d no fit, %0d count errors",
			status_seen[sfcb_pkg::STS_OK], status_seen[sfcb_pkg::STS_NOFIT],
			status_seen[sfcb_pkg::STS_COUNT]);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("timeout: %0d requests taken of %0d, %0d results owed",
			reqs_taken, reqs_queued, due_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
